>>> rtl/core/sst_pkg.sv
package sst_pkg;

   localparam int unsigned LINE_W = 16;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned CHAR_W = 8;

   // Result queue between the lexer and the output port.
   localparam int unsigned RSP_Q_DEPTH = 4;
   localparam int unsigned RSP_Q_CNT_W = $clog2(RSP_Q_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
   localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;
   localparam logic [CHAR_W-1:0] CH_DOLLAR     = 8'h24;
   localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

   localparam logic REQ_FUNC_BYTE = 1'b0;
   localparam logic REQ_FUNC_END  = 1'b1;

   typedef enum logic [8:0] {
      MODE_IDLE        = 9'b000000001,
      MODE_IDENT       = 9'b000000010,
      MODE_STRING      = 9'b000000100,
      MODE_FIELD_EMPTY = 9'b000001000,
      MODE_FIELD       = 9'b000010000,
      MODE_INT         = 9'b000100000,
      MODE_FRAC        = 9'b001000000,
      MODE_COMMENT     = 9'b010000000,
      MODE_ERROR       = 9'b100000000
   } mode_type;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      TOK_NEWLINE = 3'd0,
      TOK_IDENT   = 3'd1,
      TOK_STRING  = 3'd2,
      TOK_FIELD   = 3'd3,
      TOK_NUMBER  = 3'd4,
      TOK_END     = 3'd5
   } token_type_type;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_NL_IN_STRING = 2'd1,
      ERR_END_IN_STRING = 2'd2,
      ERR_EMPTY_FIELD  = 2'd3
   } error_code_type;

   typedef struct packed {
      mode_type          mode;
      logic [LINE_W-1:0] line;
      logic [LEN_W-1:0]  len;
   } lex_state_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] text_char;
      token_type_type    token_type;
      error_code_type    error_code;
      logic [LINE_W-1:0] line_number;
      logic [LEN_W-1:0]  text_length;
      logic              last;
   } rsp_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic rsp_type mk_text(input logic [CHAR_W-1:0] c,
                                       input token_type_type t,
                                       input logic [LINE_W-1:0] line,
                                       input logic [LEN_W-1:0] len);
      rsp_type r;
      r.kind        = KIND_TEXT;
      r.text_char   = c;
      r.token_type  = t;
      r.error_code  = ERR_NONE;
      r.line_number = line;
      r.text_length = len;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic rsp_type mk_done(input token_type_type t,
                                       input logic [LINE_W-1:0] line,
                                       input logic [LEN_W-1:0] len);
      rsp_type r;
      r.kind        = KIND_DONE;
      r.text_char   = '0;
      r.token_type  = t;
      r.error_code  = ERR_NONE;
      r.line_number = line;
      r.text_length = len;
      r.last        = 1'b0;
      return r;
   endfunction

   function automatic rsp_type mk_error(input error_code_type e,
                                        input logic [LINE_W-1:0] line);
      rsp_type r;
      r.kind        = KIND_ERROR;
      r.text_char   = '0;
      r.token_type  = TOK_NEWLINE;
      r.error_code  = e;
      r.line_number = line;
      r.text_length = '0;
      r.last        = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/core/sst_lexer.sv
module sst_lexer (
   input  sst_pkg::lex_state_type            cur,
   input  logic                              func,
   input  logic [sst_pkg::CHAR_W-1:0]        ch,
   input  logic [sst_pkg::LINE_W-1:0]        start_line,
   output sst_pkg::lex_state_type            nxt,
   output logic [1:0]                        rsp_num,
   output sst_pkg::rsp_type                  rsp0,
   output sst_pkg::rsp_type                  rsp1
);

   logic [sst_pkg::LEN_W-1:0]  len_inc;
   logic [sst_pkg::LINE_W-1:0] line_inc;
   logic                       ident_ch;

   assign len_inc  = (cur.len == '1) ? cur.len : cur.len + sst_pkg::LEN_W'(1);
   assign line_inc = (cur.line == '1) ? cur.line : cur.line + sst_pkg::LINE_W'(1);
   assign ident_ch = sst_pkg::is_alpha(ch) || (ch == sst_pkg::CH_UNDERSCORE);

   always_comb begin
      sst_pkg::rsp_type pre;
      sst_pkg::rsp_type main;
      logic             pre_valid;
      logic             main_valid;
      logic             do_idle;

      nxt        = cur;
      pre        = sst_pkg::mk_done(sst_pkg::TOK_END, cur.line, cur.len);
      main       = pre;
      pre_valid  = 1'b0;
      main_valid = 1'b0;
      do_idle    = 1'b0;

      if (func == sst_pkg::REQ_FUNC_END) begin
         main       = sst_pkg::mk_done(sst_pkg::TOK_END, cur.line, '0);
         main_valid = 1'b1;
         case (cur.mode)
            sst_pkg::MODE_STRING: begin
               main = sst_pkg::mk_error(sst_pkg::ERR_END_IN_STRING, cur.line);
            end
            sst_pkg::MODE_FIELD_EMPTY: begin
               main = sst_pkg::mk_error(sst_pkg::ERR_EMPTY_FIELD, cur.line);
            end
            sst_pkg::MODE_IDENT: begin
               pre       = sst_pkg::mk_done(sst_pkg::TOK_IDENT, cur.line, cur.len);
               pre_valid = 1'b1;
            end
            sst_pkg::MODE_FIELD: begin
               pre       = sst_pkg::mk_done(sst_pkg::TOK_FIELD, cur.line, cur.len);
               pre_valid = 1'b1;
            end
            sst_pkg::MODE_INT, sst_pkg::MODE_FRAC: begin
               pre       = sst_pkg::mk_done(sst_pkg::TOK_NUMBER, cur.line, cur.len);
               pre_valid = 1'b1;
            end
            default: begin
            end
         endcase
         nxt.mode = sst_pkg::MODE_IDLE;
         nxt.line = start_line;
         nxt.len  = '0;
      end else begin
         case (cur.mode)
            sst_pkg::MODE_ERROR: begin
            end
            sst_pkg::MODE_STRING: begin
               main_valid = 1'b1;
               if (ch == sst_pkg::CH_QUOTE) begin
                  main     = sst_pkg::mk_done(sst_pkg::TOK_STRING, cur.line, cur.len);
                  nxt.mode = sst_pkg::MODE_IDLE;
               end else if (ch == sst_pkg::CH_NEWLINE) begin
                  main     = sst_pkg::mk_error(sst_pkg::ERR_NL_IN_STRING, cur.line);
                  nxt.mode = sst_pkg::MODE_ERROR;
               end else begin
                  main    = sst_pkg::mk_text(ch, sst_pkg::TOK_STRING, cur.line, len_inc);
                  nxt.len = len_inc;
               end
            end
            sst_pkg::MODE_COMMENT: begin
               do_idle = (ch == sst_pkg::CH_NEWLINE);
            end
            sst_pkg::MODE_IDENT: begin
               if (ident_ch || sst_pkg::is_digit(ch)) begin
                  main       = sst_pkg::mk_text(ch, sst_pkg::TOK_IDENT, cur.line, len_inc);
                  main_valid = 1'b1;
                  nxt.len    = len_inc;
               end else begin
                  pre       = sst_pkg::mk_done(sst_pkg::TOK_IDENT, cur.line, cur.len);
                  pre_valid = 1'b1;
                  do_idle   = 1'b1;
               end
            end
            sst_pkg::MODE_FIELD_EMPTY: begin
               main_valid = 1'b1;
               if (sst_pkg::is_digit(ch)) begin
                  main     = sst_pkg::mk_text(ch, sst_pkg::TOK_FIELD, cur.line, len_inc);
                  nxt.len  = len_inc;
                  nxt.mode = sst_pkg::MODE_FIELD;
               end else begin
                  main     = sst_pkg::mk_error(sst_pkg::ERR_EMPTY_FIELD, cur.line);
                  nxt.mode = sst_pkg::MODE_ERROR;
               end
            end
            sst_pkg::MODE_FIELD: begin
               if (sst_pkg::is_digit(ch)) begin
                  main       = sst_pkg::mk_text(ch, sst_pkg::TOK_FIELD, cur.line, len_inc);
                  main_valid = 1'b1;
                  nxt.len    = len_inc;
               end else begin
                  pre       = sst_pkg::mk_done(sst_pkg::TOK_FIELD, cur.line, cur.len);
                  pre_valid = 1'b1;
                  do_idle   = 1'b1;
               end
            end
            sst_pkg::MODE_INT: begin
               if (sst_pkg::is_digit(ch) || (ch == sst_pkg::CH_DOT)) begin
                  main       = sst_pkg::mk_text(ch, sst_pkg::TOK_NUMBER, cur.line, len_inc);
                  main_valid = 1'b1;
                  nxt.len    = len_inc;
                  if (ch == sst_pkg::CH_DOT) begin
                     nxt.mode = sst_pkg::MODE_FRAC;
                  end
               end else begin
                  pre       = sst_pkg::mk_done(sst_pkg::TOK_NUMBER, cur.line, cur.len);
                  pre_valid = 1'b1;
                  do_idle   = 1'b1;
               end
            end
            sst_pkg::MODE_FRAC: begin
               if (sst_pkg::is_digit(ch)) begin
                  main       = sst_pkg::mk_text(ch, sst_pkg::TOK_NUMBER, cur.line, len_inc);
                  main_valid = 1'b1;
                  nxt.len    = len_inc;
               end else begin
                  pre       = sst_pkg::mk_done(sst_pkg::TOK_NUMBER, cur.line, cur.len);
                  pre_valid = 1'b1;
                  do_idle   = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         // A byte that ends a token is then handled as if between tokens.
         if (do_idle) begin
            nxt.mode = sst_pkg::MODE_IDLE;
            if (ch == sst_pkg::CH_NEWLINE) begin
               main       = sst_pkg::mk_done(sst_pkg::TOK_NEWLINE, cur.line, '0);
               main_valid = 1'b1;
               nxt.line   = line_inc;
            end else if (ch == sst_pkg::CH_HASH) begin
               nxt.mode = sst_pkg::MODE_COMMENT;
            end else if (ident_ch) begin
               main       = sst_pkg::mk_text(ch, sst_pkg::TOK_IDENT, cur.line,
                                             sst_pkg::LEN_W'(1));
               main_valid = 1'b1;
               nxt.len    = sst_pkg::LEN_W'(1);
               nxt.mode   = sst_pkg::MODE_IDENT;
            end else if (ch == sst_pkg::CH_QUOTE) begin
               nxt.len  = '0;
               nxt.mode = sst_pkg::MODE_STRING;
            end else if (ch == sst_pkg::CH_DOLLAR) begin
               nxt.len  = '0;
               nxt.mode = sst_pkg::MODE_FIELD_EMPTY;
            end else if (sst_pkg::is_digit(ch)) begin
               main       = sst_pkg::mk_text(ch, sst_pkg::TOK_NUMBER, cur.line,
                                             sst_pkg::LEN_W'(1));
               main_valid = 1'b1;
               nxt.len    = sst_pkg::LEN_W'(1);
               nxt.mode   = sst_pkg::MODE_INT;
            end
         end
      end

      if (pre_valid) begin
         rsp0    = pre;
         rsp1    = main;
         rsp_num = main_valid ? 2'd2 : 2'd1;
      end else begin
         rsp0    = main;
         rsp1    = main;
         rsp_num = main_valid ? 2'd1 : 2'd0;
      end
      rsp0.last = (rsp_num == 2'd1);
      rsp1.last = 1'b1;
   end

endmodule

>>> rtl/core/sst_rsp_queue.sv
module sst_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_num,
   input  sst_pkg::rsp_type push0,
   input  sst_pkg::rsp_type push1,
   input  logic             pop,
   output logic             not_empty,
   output logic             almost_full,
   output sst_pkg::rsp_type head
);

   sst_pkg::rsp_type                q_ff [sst_pkg::RSP_Q_DEPTH];
   sst_pkg::rsp_type                q_in [sst_pkg::RSP_Q_DEPTH];
   logic [sst_pkg::RSP_Q_CNT_W-1:0] cnt_ff;
   logic [sst_pkg::RSP_Q_CNT_W-1:0] cnt_in;
   logic [sst_pkg::RSP_Q_CNT_W-1:0] base;

   assign base        = cnt_ff - sst_pkg::RSP_Q_CNT_W'(pop);
   assign cnt_in      = base + sst_pkg::RSP_Q_CNT_W'(push_num);
   assign not_empty   = (cnt_ff != '0);
   // Room for two more results is kept so that any request can be taken.
   assign almost_full = (cnt_ff > sst_pkg::RSP_Q_CNT_W'(sst_pkg::RSP_Q_DEPTH - 2));
   assign head        = q_ff[0];

   always_comb begin
      for (int i = 0; i < sst_pkg::RSP_Q_DEPTH; i++) begin
         q_in[i] = q_ff[i];
         if (sst_pkg::RSP_Q_CNT_W'(i) < base) begin
            if (pop && (i < sst_pkg::RSP_Q_DEPTH - 1)) begin
               q_in[i] = q_ff[(i + 1) % sst_pkg::RSP_Q_DEPTH];
            end
         end else if ((sst_pkg::RSP_Q_CNT_W'(i) == base) && (push_num != 2'd0)) begin
            q_in[i] = push0;
         end else if ((sst_pkg::RSP_Q_CNT_W'(i) == base + sst_pkg::RSP_Q_CNT_W'(1)) &&
                      (push_num == 2'd2)) begin
            q_in[i] = push1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sst_pkg::RSP_Q_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

>>> rtl/core/streaming_source_tokenizer_core.sv
// Streaming source tokenizer.
// Requests arrive on the req_ channel, one source byte per request (req_func low)
// or an end-of-text marker (req_func high). A request is taken at a clock edge
// with req_valid high and req_stall low. Results leave on the rsp_ channel and
// are taken when rsp_valid is high and rsp_stall is low; rsp_last marks the
// final result of a request, which yields zero, one or two results.
// csr_wr_en with csr_wr_data sets the line number given to the first line of a
// text; it also reloads the current line when no byte of the text has been seen.
// Results are registered in the result queue and shown after earlier ones. One
// request is taken per cycle while req_stall is low; the output side moves one
// result per cycle while rsp_stall is low, so requests giving two results can
// outpace it. A four-entry result queue parts the two sides; req_stall rises
// when fewer than two entries are free, so a stalled receiver backs the input up.
// Synchronous reset returns to between tokens, line 1, empty queue.
module streaming_source_tokenizer_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_func,
   input  logic [sst_pkg::CHAR_W-1:0] req_ch,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_kind,
   output logic [sst_pkg::CHAR_W-1:0] rsp_text_char,
   output logic [2:0]                 rsp_token_type,
   output logic [1:0]                 rsp_error_code,
   output logic [sst_pkg::LINE_W-1:0] rsp_line_number,
   output logic [sst_pkg::LEN_W-1:0]  rsp_text_length,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [sst_pkg::LINE_W-1:0] csr_wr_data
);

   sst_pkg::lex_state_type        state_ff;
   sst_pkg::lex_state_type        state_in;
   sst_pkg::lex_state_type        lex_nxt;
   logic [sst_pkg::LINE_W-1:0]    start_line_ff;
   logic [sst_pkg::LINE_W-1:0]    start_line_in;
   logic                          fresh_ff;
   logic                          fresh_in;
   logic                          req_take;
   logic                          rsp_take;
   logic                          q_almost_full;
   logic [1:0]                    lex_num;
   logic [1:0]                    push_num;
   sst_pkg::rsp_type              lex_rsp0;
   sst_pkg::rsp_type              lex_rsp1;
   sst_pkg::rsp_type              q_head;

   assign req_stall = q_almost_full;
   assign req_take  = req_valid && !q_almost_full;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign push_num  = req_take ? lex_num : 2'd0;

   sst_lexer u_lexer (
      .cur        (state_ff),
      .func       (req_func),
      .ch         (req_ch),
      .start_line (start_line_ff),
      .nxt        (lex_nxt),
      .rsp_num    (lex_num),
      .rsp0       (lex_rsp0),
      .rsp1       (lex_rsp1)
   );

   sst_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push_num    (push_num),
      .push0       (lex_rsp0),
      .push1       (lex_rsp1),
      .pop         (rsp_take),
      .not_empty   (rsp_valid),
      .almost_full (q_almost_full),
      .head        (q_head)
   );

   always_comb begin
      state_in      = state_ff;
      start_line_in = start_line_ff;
      fresh_in      = fresh_ff;
      if (req_take) begin
         state_in = lex_nxt;
         fresh_in = (req_func == sst_pkg::REQ_FUNC_END);
      end
      if (csr_wr_en) begin
         start_line_in = csr_wr_data;
         if (fresh_ff) begin
            state_in.line = csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode <= sst_pkg::MODE_IDLE;
         state_ff.line <= sst_pkg::LINE_W'(1);
         state_ff.len  <= '0;
         start_line_ff <= sst_pkg::LINE_W'(1);
         fresh_ff      <= 1'b1;
      end else begin
         state_ff      <= state_in;
         start_line_ff <= start_line_in;
         fresh_ff      <= fresh_in;
      end
   end

   assign rsp_kind        = q_head.kind;
   assign rsp_text_char   = q_head.text_char;
   assign rsp_token_type  = q_head.token_type;
   assign rsp_error_code  = q_head.error_code;
   assign rsp_line_number = q_head.line_number;
   assign rsp_text_length = q_head.text_length;
   assign rsp_last        = q_head.last;

endmodule
